// File: src/assert_macros.svh
// assertion macros for the queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/fspq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fspq_pkg
// shared types and codes for the filtered stable priority queue
// ----------------------------------------------------------------------------
package fspq_pkg;
	localparam int DEF_QUEUE_DEPTH     = 32;
	localparam int DEF_PRIORITY_LEVELS = 4;
	localparam int DEF_KIND_COUNT      = 8;

	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_POP   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	localparam logic [1:0] UF_NORMAL   = 2'd0;
	localparam logic [1:0] UF_UNLOAD   = 2'd1;
	localparam logic [1:0] UF_ANY      = 2'd2;
	localparam logic [1:0] UF_RESERVED = 2'd3;

	localparam logic CFG_FALLBACK_PRIORITY = 1'b0;
	localparam logic CFG_FALLBACK_KIND     = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic search;
		logic commit;
	} fspq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] op;
	} fspq_status_t;
endpackage

// File: src/fspq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fspq_ctrl
// sequencer: capture request, search, commit result
// ----------------------------------------------------------------------------
module fspq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  fspq_pkg::fspq_status_t status,
	output fspq_pkg::fspq_cmd_t   cmd
);
	import fspq_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;

	logic [1:0] state_q;
	logic       take;

	assign take = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd.capture = take;
		cmd.search  = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			ST_SEARCH: begin
				cmd.search = (status.op == OP_POP);
				cmd.commit = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE:   if (take) state_q <= ST_SEARCH;
				ST_SEARCH: state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: src/fspq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fspq_dp
// entry registers, parallel match and priority pick, shift-remove
// ----------------------------------------------------------------------------
module fspq_dp #(
	parameter int QUEUE_DEPTH     = fspq_pkg::DEF_QUEUE_DEPTH,
	parameter int PRIORITY_LEVELS = fspq_pkg::DEF_PRIORITY_LEVELS,
	parameter int KIND_COUNT      = fspq_pkg::DEF_KIND_COUNT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  fspq_pkg::fspq_cmd_t    cmd,
	output fspq_pkg::fspq_status_t status,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [2:0]             cfg_data,
	input  logic [1:0]             op,
	input  logic [15:0]            action_id,
	input  logic [31:0]            user_tag,
	input  logic [15:0]            clip_ref,
	input  logic [2:0]             priority_req,
	input  logic [3:0]             kind,
	input  logic                   unload_mark,
	input  logic [7:0]             kind_mask,
	input  logic [1:0]             unload_filter,
	output logic                   done,
	output logic                   found,
	output logic [15:0]            action_id_out,
	output logic [31:0]            user_tag_out,
	output logic [15:0]            clip_ref_out,
	output logic [1:0]             priority_out,
	output logic [2:0]             kind_out,
	output logic                   unload_mark_out,
	output logic                   more_unload,
	output logic                   dropped,
	output logic [5:0]             occupancy
);
	import fspq_pkg::*;

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [15:0] clip;
		logic [31:0] tag;
		logic [15:0] aid;
	} payload_t;

	typedef struct packed {
		logic       unl;
		logic [2:0] knd;
		logic [2:0] pri;
	} tags_t;

	payload_t          pl_q [QUEUE_DEPTH];
	tags_t             tg_q [QUEUE_DEPTH];
	logic [CW-1:0]     count_q;
	logic [1:0]        fb_pri_q;
	logic [2:0]        fb_kind_q;

	logic [1:0]        op_q;
	payload_t          in_pl_q;
	tags_t             in_tg_q;
	logic [7:0]        kmask_q;
	logic [1:0]        uf_q;

	// registered search result
	logic [QUEUE_DEPTH-1:0] best_s1;

	logic [QUEUE_DEPTH-1:0] match;
	logic [QUEUE_DEPTH-1:0] top_pri;
	logic [QUEUE_DEPTH-1:0] first;
	logic [2:0]             max_pri;
	logic                   any_hit;
	logic [QUEUE_DEPTH-1:0] shift_en;
	logic [QUEUE_DEPTH-1:0] unl_vec;
	payload_t               hit_pl;
	tags_t                  hit_tg;

	assign status.op = op_q;

	// per-entry filter
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			match[i] = (CW'(i) < count_q) && kmask_q[tg_q[i].knd]
				&& !((uf_q == UF_NORMAL) && tg_q[i].unl)
				&& !((uf_q == UF_UNLOAD) && !tg_q[i].unl);
		end
	end

	// highest matching priority, then earliest entry of that priority
	always_comb begin
		max_pri = '0;
		for (int p = 0; p < PRIORITY_LEVELS; p++) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				if (match[i] && tg_q[i].pri == 3'(p)) max_pri = 3'(p);
			end
		end
		for (int i = 0; i < QUEUE_DEPTH; i++)
			top_pri[i] = match[i] && (tg_q[i].pri == max_pri);
		first = top_pri & (~top_pri + QUEUE_DEPTH'(1));
	end

	always_comb begin
		any_hit  = |best_s1;
		hit_pl   = '0;
		hit_tg   = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (best_s1[i]) begin
				hit_pl = pl_q[i];
				hit_tg = tg_q[i];
			end
		end
		// entries at or after the hit move down one place
		shift_en = '0;
		for (int i = 1; i < QUEUE_DEPTH; i++)
			shift_en[i] = shift_en[i-1] | best_s1[i-1];
		shift_en[0] = 1'b0;
		for (int i = 0; i < QUEUE_DEPTH; i++)
			shift_en[i] = shift_en[i] | best_s1[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_pri_q  <= 2'd1;
			fb_kind_q <= 3'd0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_FALLBACK_PRIORITY) fb_pri_q <= cfg_data[1:0];
			else fb_kind_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q        <= op;
			in_pl_q.aid <= action_id;
			in_pl_q.tag <= user_tag;
			in_pl_q.clip <= clip_ref;
			in_tg_q.unl <= unload_mark;
			in_tg_q.pri <= (32'(priority_req) < PRIORITY_LEVELS) ? priority_req
				: {1'b0, fb_pri_q};
			in_tg_q.knd <= (32'(kind) < KIND_COUNT) ? kind[2:0] : fb_kind_q;
			kmask_q     <= kind_mask;
			uf_q        <= unload_filter;
			best_s1     <= '0;
		end else if (cmd.search) begin
			best_s1  <= first;
		end
	end

	logic commit_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) commit_q <= 1'b0;
		else commit_q <= cmd.commit;
	end

	// pop removes in the cycle after the search
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			if (op_q == OP_PUSH && in_pl_q.aid != '0 && count_q < CW'(QUEUE_DEPTH))
				count_q <= count_q + CW'(1);
			else if (op_q == OP_CLEAR)
				count_q <= '0;
		end else if (commit_q && op_q == OP_POP && any_hit) begin
			count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && op_q == OP_PUSH && in_pl_q.aid != '0
				&& count_q < CW'(QUEUE_DEPTH)) begin
			pl_q[count_q[IW-1:0]] <= in_pl_q;
			tg_q[count_q[IW-1:0]] <= in_tg_q;
		end else if (commit_q && op_q == OP_POP && any_hit) begin
			for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
				if (shift_en[i]) begin
					pl_q[i] <= pl_q[i+1];
					tg_q[i] <= tg_q[i+1];
				end
			end
		end
	end

	// result, registered through pend_q and done_q after the state update
	logic [CW-1:0] cnt_after;
	always_comb begin
		cnt_after = count_q;
		for (int i = 0; i < QUEUE_DEPTH; i++)
			unl_vec[i] = (CW'(i) < count_q) && tg_q[i].unl;
	end

	logic done_q, pend_q, found_q, drop_q;
	payload_t out_pl_q;
	tags_t    out_tg_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			pend_q <= commit_q;
			done_q <= pend_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			drop_q <= (op_q == OP_PUSH) && (in_pl_q.aid != '0)
				&& (count_q >= CW'(QUEUE_DEPTH));
		end
		if (commit_q) begin
			found_q  <= (op_q == OP_POP) && any_hit;
			out_pl_q <= (op_q == OP_POP && any_hit) ? hit_pl : '0;
			out_tg_q <= (op_q == OP_POP && any_hit) ? hit_tg : '0;
		end
		if (pend_q) begin
			more_unload     <= |unl_vec;
			occupancy       <= 6'(cnt_after);
			found           <= found_q;
			dropped         <= drop_q;
			action_id_out   <= out_pl_q.aid;
			user_tag_out    <= out_pl_q.tag;
			clip_ref_out    <= out_pl_q.clip;
			priority_out    <= out_tg_q.pri[1:0];
			kind_out        <= out_tg_q.knd;
			unload_mark_out <= out_tg_q.unl;
		end
	end

	assign done = done_q;
endmodule

// File: src/filtered_stable_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filtered_stable_priority_queue
// bounded stable priority queue with filtered pop
// ----------------------------------------------------------------------------
// One request is taken when start is high and busy is low; busy is then high
// for the one cycle that follows, and no new request is taken while it is
// high (capture at the accepting edge, then a parallel match and priority
// pick over all entries, then the one-place shift of the entries behind a
// popped one, overlapping the next capture). The result appears for one
// cycle on result_valid, registered through commit_q, pend_q and done_q,
// and cannot be held off; a new request can be taken while it is shown.
`include "assert_macros.svh"

module filtered_stable_priority_queue #(
	parameter int QUEUE_DEPTH     = fspq_pkg::DEF_QUEUE_DEPTH,
	parameter int PRIORITY_LEVELS = fspq_pkg::DEF_PRIORITY_LEVELS,
	parameter int KIND_COUNT      = fspq_pkg::DEF_KIND_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [2:0]  cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [15:0] action_id,
	input  logic [31:0] user_tag,
	input  logic [15:0] clip_ref,
	input  logic [2:0]  priority_req,
	input  logic [3:0]  kind,
	input  logic        unload_mark,
	input  logic [7:0]  kind_mask,
	input  logic [1:0]  unload_filter,
	output logic        result_valid,
	output logic        found,
	output logic [15:0] action_id_out,
	output logic [31:0] user_tag_out,
	output logic [15:0] clip_ref_out,
	output logic [1:0]  priority_out,
	output logic [2:0]  kind_out,
	output logic        unload_mark_out,
	output logic        more_unload,
	output logic        dropped,
	output logic [5:0]  occupancy
);
	import fspq_pkg::*;

	fspq_cmd_t    cmd;
	fspq_status_t status;

	fspq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.status(status), .cmd(cmd)
	);

	fspq_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH), .PRIORITY_LEVELS(PRIORITY_LEVELS),
		.KIND_COUNT(KIND_COUNT)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.op(op), .action_id(action_id), .user_tag(user_tag), .clip_ref(clip_ref),
		.priority_req(priority_req), .kind(kind), .unload_mark(unload_mark),
		.kind_mask(kind_mask), .unload_filter(unload_filter),
		.done(result_valid), .found(found), .action_id_out(action_id_out),
		.user_tag_out(user_tag_out), .clip_ref_out(clip_ref_out),
		.priority_out(priority_out), .kind_out(kind_out),
		.unload_mark_out(unload_mark_out), .more_unload(more_unload),
		.dropped(dropped), .occupancy(occupancy)
	);

	`ASSERT_NEXT(a_busy_after_start, clk, arst_n, start && !busy, busy, "no busy after start")
	`ASSERT_IMP(a_found_not_drop, clk, arst_n, result_valid, !(found && dropped), "found, dropped")
	`ASSERT_IMP(a_occ_range, clk, arst_n, result_valid, occupancy <= 6'(QUEUE_DEPTH), "occupancy")
endmodule
